FILE: hw/rtl/dq_pkg.sv
// Shared widths, codes, types and slot arithmetic for the double-ended queue.
`timescale 1ns / 1ps
package dq_pkg;

    localparam int DEPTH  = 16;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam int OP_W   = 3;
    localparam int DATA_W = 64;
    localparam int POS_W  = 4;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 5;

    // Width in which a position and the entry count can be compared.
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_PEEK       = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [ADDR_W-1:0] addr;
    } t_mem_op;

    // Circular slot addition; both operands are below DEPTH.
    function automatic logic [ADDR_W-1:0] slot_add(
        input logic [ADDR_W-1:0] base,
        input logic [ADDR_W-1:0] offset
    );
        logic [ADDR_W:0] sum;
        sum = {1'b0, base} + {1'b0, offset};
        if (sum >= (ADDR_W + 1)'(DEPTH)) begin
            sum = sum - (ADDR_W + 1)'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] slot_before(input logic [ADDR_W-1:0] base);
        logic [ADDR_W-1:0] prev;
        if (base == '0) begin
            prev = ADDR_W'(DEPTH - 1);
        end else begin
            prev = base - 1'b1;
        end
        return prev;
    endfunction

endpackage

FILE: hw/rtl/dq_req_if.sv
// Request channel of the double-ended queue: valid, ready and the request fields.
`timescale 1ns / 1ps
interface dq_req_if;
    import dq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          operation;
    logic signed [DATA_W-1:0] push_value;
    logic [POS_W-1:0]         position;

    modport source (output valid, output operation, output push_value, output position,
                    input ready);
    modport sink   (input valid, input operation, input push_value, input position,
                    output ready);
endinterface

FILE: hw/rtl/dq_rsp_if.sv
// Response channel of the double-ended queue: valid, ready and the result fields.
`timescale 1ns / 1ps
interface dq_rsp_if;
    import dq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] result_value;
    logic [STAT_W-1:0]        status;
    logic [OCC_W-1:0]         occupancy;

    modport source (output valid, output result_value, output status, output occupancy,
                    input ready);
    modport sink   (input valid, input result_value, input status, input occupancy,
                    output ready);
endinterface

FILE: hw/rtl/dq_ctrl.sv
// Front pointer and entry count, status decode and store address for each request.
`timescale 1ns / 1ps
module dq_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [dq_pkg::OP_W-1:0]     i_operation,
    input  logic [dq_pkg::POS_W-1:0]    i_position,
    output dq_pkg::t_mem_op             o_mem_op,
    output logic [dq_pkg::STAT_W-1:0]   o_status,
    output logic [dq_pkg::OCC_W-1:0]    o_occupancy
);
    import dq_pkg::*;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    logic [ADDR_W-1:0] r_front, n_front;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CMP_W-1:0]  pos_wide;
    logic              is_full;
    logic              is_empty;

    assign pos_wide = CMP_W'(i_position);
    assign is_full  = (r_count == DEPTH_CNT);
    assign is_empty = (r_count == '0);

    always_comb begin
        n_front  = r_front;
        n_count  = r_count;
        o_mem_op = '0;
        o_status = ST_OK;
        if (i_accept) begin
            unique case (i_operation)
                OP_PUSH_FRONT: begin
                    if (is_full) begin
                        o_status = ST_FULL;
                    end else begin
                        n_front        = slot_before(r_front);
                        o_mem_op.wr_en = 1'b1;
                        o_mem_op.addr  = n_front;
                        n_count        = r_count + 1'b1;
                    end
                end
                OP_PUSH_BACK: begin
                    if (is_full) begin
                        o_status = ST_FULL;
                    end else begin
                        o_mem_op.wr_en = 1'b1;
                        o_mem_op.addr  = slot_add(r_front, r_count[ADDR_W-1:0]);
                        n_count        = r_count + 1'b1;
                    end
                end
                OP_POP_FRONT: begin
                    if (is_empty) begin
                        o_status = ST_EMPTY;
                    end else begin
                        o_mem_op.rd_en = 1'b1;
                        o_mem_op.addr  = r_front;
                        n_front        = slot_add(r_front, ADDR_W'(1));
                        n_count        = r_count - 1'b1;
                    end
                end
                OP_POP_BACK: begin
                    if (is_empty) begin
                        o_status = ST_EMPTY;
                    end else begin
                        n_count        = r_count - 1'b1;
                        o_mem_op.rd_en = 1'b1;
                        o_mem_op.addr  = slot_add(r_front, n_count[ADDR_W-1:0]);
                    end
                end
                OP_PEEK: begin
                    if (pos_wide >= CMP_W'(r_count)) begin
                        o_status = ST_NOT_FOUND;
                    end else begin
                        o_mem_op.rd_en = 1'b1;
                        o_mem_op.addr  = slot_add(r_front, pos_wide[ADDR_W-1:0]);
                    end
                end
                default: begin
                    // Unused operation codes leave the queue untouched.
                end
            endcase
        end
    end

    assign o_occupancy = OCC_W'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else begin
            r_front <= n_front;
            r_count <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_CNT)
        else $error("entry count exceeds depth");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_status == ST_FULL) |-> (r_count == DEPTH_CNT))
        else $error("full status while queue has room");

    a_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_mem_op.wr_en && o_mem_op.rd_en))
        else $error("store written and read by one request");

    a_push_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_operation == OP_PUSH_BACK && !is_full)
        |=> (r_count == $past(r_count) + 1'b1) && (r_front == $past(r_front)))
        else $error("push at back did not grow the queue by one");

endmodule

FILE: hw/rtl/dq_store.sv
// Entry store of the queue: one write or one registered read per request.
`timescale 1ns / 1ps
module dq_store (
    input  logic                             i_clk,
    input  logic                             i_load,
    input  dq_pkg::t_mem_op                  i_mem_op,
    input  logic signed [dq_pkg::DATA_W-1:0] i_wdata,
    output logic signed [dq_pkg::DATA_W-1:0] o_rdata
);
    import dq_pkg::*;

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_mem_op.wr_en) begin
            mem[i_mem_op.addr] <= i_wdata;
        end
    end

    // Read data is zero for every request that does not return an entry,
    // and holds while the response waits.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            if (i_mem_op.rd_en) begin
                r_rdata <= mem[i_mem_op.addr];
            end else begin
                r_rdata <= '0;
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/double_ended_queue.sv
// Top level of the bounded double-ended queue of signed 64-bit values.
// A request is accepted every cycle in which the response register is empty or is being
// taken; its response appears in the next cycle, so while responses are taken the
// rate is one request per cycle, with a single-port entry store whose read data is
// registered. Each request returns exactly one response carrying the popped or peeked
// value (zero otherwise), a status and the number of entries held after the request.
// The queue holds up to 16 entries; a push into a full queue, a pop from an empty one
// and a peek beyond the count leave the contents unchanged and report it in the status.
`timescale 1ns / 1ps
module double_ended_queue (
    input  logic     i_clk,
    input  logic     i_rst_n,
    dq_req_if.sink   i_req,
    dq_rsp_if.source o_rsp
);
    import dq_pkg::*;

    logic              accept;
    t_mem_op           mem_op;
    logic [STAT_W-1:0] status;
    logic [OCC_W-1:0]  occupancy;

    logic              r_out_valid;
    logic [STAT_W-1:0] r_status;
    logic [OCC_W-1:0]  r_occupancy;

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;

    dq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_operation (i_req.operation),
        .i_position  (i_req.position),
        .o_mem_op    (mem_op),
        .o_status    (status),
        .o_occupancy (occupancy)
    );

    dq_store u_store (
        .i_clk    (i_clk),
        .i_load   (accept),
        .i_mem_op (mem_op),
        .i_wdata  (i_req.push_value),
        .o_rdata  (o_rsp.result_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status    <= status;
            r_occupancy <= occupancy;
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.status    = r_status;
    assign o_rsp.occupancy = r_occupancy;

endmodule
